// File: rtl/scfcc_pkg.sv
// Shared types, constants, class tables and size-to-class mapping for the free chunk cache.
package scfcc_pkg;

  localparam int NUM_CLASSES = 64;
  localparam int CLASS_W     = 6;
  localparam int SIZE_W      = 17;

  localparam logic [31:0] SMALL_MAX = 32'd4096;
  localparam logic [31:0] LARGE_MAX = 32'd65536;

  // Operation codes on the input channel.
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_REALLOC = 2'd2;

  // Allocation outcome codes.
  localparam logic [1:0] ALLOC_NONE   = 2'd0;
  localparam logic [1:0] ALLOC_REUSED = 2'd1;
  localparam logic [1:0] ALLOC_SYSTEM = 2'd2;

  // Free outcome codes.
  localparam logic [1:0] FREE_NONE    = 2'd0;
  localparam logic [1:0] FREE_CACHED  = 2'd1;
  localparam logic [1:0] FREE_RELEASE = 2'd2;

  // Byte size of each class.
  localparam logic [SIZE_W-1:0] CLASS_BYTES [NUM_CLASSES] = '{
    17'd64,    17'd128,   17'd192,   17'd256,   17'd320,   17'd384,   17'd448,   17'd512,
    17'd576,   17'd640,   17'd704,   17'd768,   17'd832,   17'd896,   17'd960,   17'd1024,
    17'd1152,  17'd1280,  17'd1408,  17'd1536,  17'd1664,  17'd1792,  17'd1920,  17'd2048,
    17'd2304,  17'd2560,  17'd2816,  17'd3072,  17'd3328,  17'd3584,  17'd3840,  17'd4096,
    17'd4608,  17'd5120,  17'd5632,  17'd6144,  17'd6656,  17'd7168,  17'd7680,  17'd8192,
    17'd9216,  17'd10240, 17'd11264, 17'd12288, 17'd13312, 17'd14336, 17'd15360, 17'd16384,
    17'd18432, 17'd20480, 17'd22528, 17'd24576, 17'd26624, 17'd28672, 17'd30720, 17'd32768,
    17'd36864, 17'd40960, 17'd45056, 17'd49152, 17'd53248, 17'd57344, 17'd61440, 17'd65536
  };

  // Class of a size rounded up to 64 bytes, indexed by (rounded / 64) - 1.
  localparam logic [CLASS_W-1:0] SMALL_MAP [64] = '{
    6'd0,  6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd6,  6'd7,
    6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15,
    6'd16, 6'd16, 6'd17, 6'd17, 6'd18, 6'd18, 6'd19, 6'd19,
    6'd20, 6'd20, 6'd21, 6'd21, 6'd22, 6'd22, 6'd23, 6'd23,
    6'd24, 6'd24, 6'd24, 6'd24, 6'd25, 6'd25, 6'd25, 6'd25,
    6'd26, 6'd26, 6'd26, 6'd26, 6'd27, 6'd27, 6'd27, 6'd27,
    6'd28, 6'd28, 6'd28, 6'd28, 6'd29, 6'd29, 6'd29, 6'd29,
    6'd30, 6'd30, 6'd30, 6'd30, 6'd31, 6'd31, 6'd31, 6'd31
  };

  // Class of a size rounded up to 512 bytes, indexed by (rounded / 512) - 1.
  localparam logic [CLASS_W-1:0] LARGE_MAP [128] = '{
    6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,
    6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39,
    6'd40, 6'd40, 6'd41, 6'd41, 6'd42, 6'd42, 6'd43, 6'd43,
    6'd44, 6'd44, 6'd45, 6'd45, 6'd46, 6'd46, 6'd47, 6'd47,
    6'd48, 6'd48, 6'd48, 6'd48, 6'd49, 6'd49, 6'd49, 6'd49,
    6'd50, 6'd50, 6'd50, 6'd50, 6'd51, 6'd51, 6'd51, 6'd51,
    6'd52, 6'd52, 6'd52, 6'd52, 6'd53, 6'd53, 6'd53, 6'd53,
    6'd54, 6'd54, 6'd54, 6'd54, 6'd55, 6'd55, 6'd55, 6'd55,
    6'd56, 6'd56, 6'd56, 6'd56, 6'd56, 6'd56, 6'd56, 6'd56,
    6'd57, 6'd57, 6'd57, 6'd57, 6'd57, 6'd57, 6'd57, 6'd57,
    6'd58, 6'd58, 6'd58, 6'd58, 6'd58, 6'd58, 6'd58, 6'd58,
    6'd59, 6'd59, 6'd59, 6'd59, 6'd59, 6'd59, 6'd59, 6'd59,
    6'd60, 6'd60, 6'd60, 6'd60, 6'd60, 6'd60, 6'd60, 6'd60,
    6'd61, 6'd61, 6'd61, 6'd61, 6'd61, 6'd61, 6'd61, 6'd61,
    6'd62, 6'd62, 6'd62, 6'd62, 6'd62, 6'd62, 6'd62, 6'd62,
    6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63
  };

  // One result item as it leaves the block.
  typedef struct packed {
    logic [1:0]  alloc_action;
    logic [31:0] alloc_handle;
    logic [31:0] alloc_size;
    logic [1:0]  free_action;
    logic        in_place;
    logic        copy_needed;
    logic        null_result;
  } result_t;

  // Class of a size of at most 65536 bytes; size zero maps to the smallest class.
  function automatic logic [CLASS_W-1:0] size_class(input logic [SIZE_W-1:0] size);
    logic [SIZE_W:0] sum;
    logic [8:0]      units;
    logic [8:0]      idx;
    if (size <= SMALL_MAX[SIZE_W-1:0]) begin
      sum   = {1'b0, size} + 18'd63;
      units = {2'b00, sum[12:6]};
      if (units == 9'd0) begin
        units = 9'd1;
      end
      idx = units - 9'd1;
      return SMALL_MAP[idx[5:0]];
    end
    sum   = {1'b0, size} + 18'd511;
    units = sum[17:9];
    idx   = units - 9'd1;
    return LARGE_MAP[idx[6:0]];
  endfunction

endpackage

// File: rtl/size_class_free_chunk_cache.sv
// Top level of the size-class free chunk cache: request decode, count and handle memories.
//
// Usage: requests arrive on the slave channel (s_tvalid/s_tready), the opcode in s_tuser
// and req_size, handle and chunk_size in s_tdata. Each request produces exactly one
// result transfer on the master channel (m_tvalid/m_tready, all result fields in m_tdata).
// The block handles one request at a time. A request that touches no cache memory goes
// from its decode step straight to the result step. A request that allocates through a
// class adds a read of the class count memory and, for a reuse, a handle memory read; one
// that frees through a class adds a count read for the free class, so a reallocation that
// moves a chunk does both. Each memory read is registered.
// The result sits in an output register; s_tready rises again as soon as the result is
// loaded, so the next request can be taken while the result waits for the receiver.
// A new request is taken only after the result of the last one has been loaded.
// While the receiver stalls and the output register is still full, a finished request
// waits in the result step and no further request is taken.
// Reset empties every class cache at once through per-class valid bits on the count
// memory; the handle memory is not cleared, since a slot is only read after it is written.
// Reset also drops any result that has not been transferred.
module size_class_free_chunk_cache #(
  parameter int SLOT_DEPTH   = 64,
  parameter int HANDLE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // req_size[31:0], handle[63:32], chunk_size[95:64]
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata    // alloc_action[1:0], alloc_handle[33:2], alloc_size[65:34],
                                 // free_action[67:66], in_place[68], copy_needed[69],
                                 // null_result[70], zero pad[71]
);

  localparam int NCLS   = scfcc_pkg::NUM_CLASSES;
  localparam int CLS_W  = scfcc_pkg::CLASS_W;
  localparam int CNT_W  = $clog2(SLOT_DEPTH + 1);
  localparam int SLOT_W = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int ADDR_W = $clog2(NCLS * SLOT_DEPTH);
  localparam int CAP_W  = 15;
  localparam int HW     = HANDLE_WIDTH;

  // Sequencer codes.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DEC    = 3'd1;
  localparam logic [2:0] ST_A_CNT  = 3'd2;
  localparam logic [2:0] ST_A_HND  = 3'd3;
  localparam logic [2:0] ST_F_CNT  = 3'd4;
  localparam logic [2:0] ST_RESULT = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // Request registers.
  logic [1:0]  op;
  logic [31:0] req_size;
  logic [31:0] handle_in;
  logic [31:0] chunk_size;

  // Decoded request.
  logic [CLS_W-1:0] a_cls;
  logic [CLS_W-1:0] f_cls;
  logic             free_mem;
  logic [HW-1:0]    h_masked;
  scfcc_pkg::result_t res;

  // Output register.
  scfcc_pkg::result_t out_res;

  // Class count memory with per-class valid bits.
  logic [CNT_W-1:0] cnt_mem [NCLS];
  logic [NCLS-1:0]  cnt_vld;
  logic [CNT_W-1:0] cnt_rdata;
  logic             cnt_rvld;
  logic             cnt_rd_en;
  logic [CLS_W-1:0] cnt_rd_addr;
  logic             cnt_wr_en;
  logic [CLS_W-1:0] cnt_wr_addr;
  logic [CNT_W-1:0] cnt_wr_data;
  logic [CNT_W-1:0] cnt_cur;

  // Handle memory.
  logic [HW-1:0]     hnd_mem [NCLS * SLOT_DEPTH];
  logic [HW-1:0]     hnd_rdata;
  logic              hnd_rd_en;
  logic              hnd_wr_en;
  logic [ADDR_W-1:0] hnd_addr;

  // Decode signals.
  logic [HW+31:0]         h_ext;
  logic [HW+31:0]         hm_ext;
  logic                   h_nz;
  logic                   do_alloc;
  logic                   do_free;
  logic                   dec_in_place;
  logic                   dec_null;
  logic                   dec_copy;
  logic                   alloc_big;
  logic [CLS_W-1:0]       dec_a_cls;
  logic [CLS_W-1:0]       dec_f_cls;
  logic                   f_size_ok;
  logic                   f_exact;
  logic [CAP_W-1:0]       cap_lim;
  logic [CAP_W-1:0]       cap;
  logic [SLOT_W-1:0]      pop_slot;
  logic [SLOT_W-1:0]      push_slot;
  logic [HW+31:0]         hq_ext;
  logic                   out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Handles are kept to HANDLE_WIDTH bits.
  assign h_ext    = {{HW{1'b0}}, handle_in};
  assign h_masked = h_ext[HW-1:0];
  assign hm_ext   = {32'd0, h_masked};
  assign h_nz     = |h_masked;
  assign hq_ext   = {32'd0, hnd_rdata};

  // Operation decode from the request registers.
  always_comb begin
    do_alloc     = 1'b0;
    do_free      = 1'b0;
    dec_in_place = 1'b0;
    dec_null     = 1'b0;
    dec_copy     = 1'b0;
    unique case (op)
      scfcc_pkg::OP_ALLOC: begin
        do_alloc = 1'b1;
      end
      scfcc_pkg::OP_FREE: begin
        do_free = 1'b1;
      end
      scfcc_pkg::OP_REALLOC: begin
        if (req_size == 32'd0 && h_nz) begin
          do_free  = 1'b1;
          dec_null = 1'b1;
        end else if (!h_nz) begin
          do_alloc = 1'b1;
        end else if (req_size <= chunk_size) begin
          dec_in_place = 1'b1;
        end else begin
          do_alloc = 1'b1;
          do_free  = 1'b1;
          dec_copy = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Class lookup for the allocation size and for the size in the chunk header.
  assign alloc_big = req_size > scfcc_pkg::LARGE_MAX;
  assign dec_a_cls = scfcc_pkg::size_class(req_size[scfcc_pkg::SIZE_W-1:0]);
  assign f_size_ok = (chunk_size != 32'd0) && (chunk_size <= scfcc_pkg::LARGE_MAX);
  assign dec_f_cls = scfcc_pkg::size_class(chunk_size[scfcc_pkg::SIZE_W-1:0]);
  assign f_exact   = f_size_ok &&
                     (scfcc_pkg::CLASS_BYTES[dec_f_cls] == chunk_size[scfcc_pkg::SIZE_W-1:0]);

  // Cache cap of the free class: the class limit, bounded by the slot depth.
  assign cap_lim = CAP_W'(16384) >> f_cls[5:3];
  assign cap     = (cap_lim < CAP_W'(SLOT_DEPTH)) ? cap_lim : CAP_W'(SLOT_DEPTH);

  // Count as seen after reset: a class never written holds zero.
  assign cnt_cur   = cnt_rvld ? cnt_rdata : '0;
  assign pop_slot  = SLOT_W'(cnt_cur - CNT_W'(1));
  assign push_slot = SLOT_W'(cnt_cur);

  // Memory port control and sequencing.
  always_comb begin
    state_next  = state;
    cnt_rd_en   = 1'b0;
    cnt_rd_addr = a_cls;
    cnt_wr_en   = 1'b0;
    cnt_wr_addr = a_cls;
    cnt_wr_data = cnt_cur - CNT_W'(1);
    hnd_rd_en   = 1'b0;
    hnd_wr_en   = 1'b0;
    hnd_addr    = ADDR_W'(a_cls) * ADDR_W'(SLOT_DEPTH) + ADDR_W'(pop_slot);
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_DEC;
        end
      end
      ST_DEC: begin
        if (do_alloc && !alloc_big) begin
          cnt_rd_en   = 1'b1;
          cnt_rd_addr = dec_a_cls;
          state_next  = ST_A_CNT;
        end else if (do_free && h_nz && f_exact) begin
          cnt_rd_en   = 1'b1;
          cnt_rd_addr = dec_f_cls;
          state_next  = ST_F_CNT;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_A_CNT: begin
        if (cnt_cur != '0) begin
          cnt_wr_en  = 1'b1;
          hnd_rd_en  = 1'b1;
          state_next = ST_A_HND;
        end else if (free_mem) begin
          cnt_rd_en   = 1'b1;
          cnt_rd_addr = f_cls;
          state_next  = ST_F_CNT;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_A_HND: begin
        if (free_mem) begin
          cnt_rd_en   = 1'b1;
          cnt_rd_addr = f_cls;
          state_next  = ST_F_CNT;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_F_CNT: begin
        cnt_wr_addr = f_cls;
        cnt_wr_data = cnt_cur + CNT_W'(1);
        hnd_addr    = ADDR_W'(f_cls) * ADDR_W'(SLOT_DEPTH) + ADDR_W'(push_slot);
        if (CAP_W'(cnt_cur) < cap) begin
          cnt_wr_en = 1'b1;
          hnd_wr_en = 1'b1;
        end
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      cnt_vld  <= '0;
    end else begin
      state <= state_next;
      if (cnt_wr_en) begin
        cnt_vld[cnt_wr_addr] <= 1'b1;
      end
      if (state == ST_RESULT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Count memory: one read and one write port, registered read.
  always_ff @(posedge clk) begin
    if (cnt_wr_en) begin
      cnt_mem[cnt_wr_addr] <= cnt_wr_data;
    end
    if (cnt_rd_en) begin
      cnt_rdata <= cnt_mem[cnt_rd_addr];
      cnt_rvld  <= cnt_vld[cnt_rd_addr];
    end
  end

  // Handle memory: one shared address, registered read.
  always_ff @(posedge clk) begin
    if (hnd_wr_en) begin
      hnd_mem[hnd_addr] <= h_masked;
    end
    if (hnd_rd_en) begin
      hnd_rdata <= hnd_mem[hnd_addr];
    end
  end

  // Request capture and result build-up.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      op         <= s_tuser;
      req_size   <= s_tdata[31:0];
      handle_in  <= s_tdata[63:32];
      chunk_size <= s_tdata[95:64];
    end
    unique case (state)
      ST_DEC: begin
        a_cls                 <= dec_a_cls;
        f_cls                 <= dec_f_cls;
        free_mem              <= do_free && h_nz && f_exact;
        res.alloc_action      <= (do_alloc && alloc_big) ? scfcc_pkg::ALLOC_SYSTEM
                                                         : scfcc_pkg::ALLOC_NONE;
        res.alloc_handle      <= dec_in_place ? hm_ext[31:0] : 32'd0;
        res.alloc_size        <= !do_alloc ? 32'd0 :
                                 alloc_big ? req_size :
                                 32'(scfcc_pkg::CLASS_BYTES[dec_a_cls]);
        res.free_action       <= (do_free && h_nz && !f_exact) ? scfcc_pkg::FREE_RELEASE
                                                               : scfcc_pkg::FREE_NONE;
        res.in_place          <= dec_in_place;
        res.copy_needed       <= dec_copy;
        res.null_result       <= dec_null;
      end
      ST_A_CNT: begin
        res.alloc_action <= (cnt_cur != '0) ? scfcc_pkg::ALLOC_REUSED
                                            : scfcc_pkg::ALLOC_SYSTEM;
      end
      ST_A_HND: begin
        res.alloc_handle <= hq_ext[31:0];
      end
      ST_F_CNT: begin
        res.free_action <= (CAP_W'(cnt_cur) < cap) ? scfcc_pkg::FREE_CACHED
                                                   : scfcc_pkg::FREE_RELEASE;
      end
      ST_RESULT: begin
        if (out_free) begin
          out_res <= res;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_tdata = {1'b0, out_res.null_result, out_res.copy_needed, out_res.in_place,
                    out_res.free_action, out_res.alloc_size, out_res.alloc_handle,
                    out_res.alloc_action};

endmodule

// File: rtl/scfcc_checker.sv
// Port-level checks for the free chunk cache, bound to its top level.
module scfcc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // After a request transfer the block is not ready again in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while previous one is in progress");

  // A chunk kept in place neither allocates nor frees.
  a_in_place_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[68] |->
      m_tdata[1:0] == scfcc_pkg::ALLOC_NONE && m_tdata[67:66] == scfcc_pkg::FREE_NONE &&
      !m_tdata[69] && !m_tdata[70])
    else $error("in-place result reports other activity");

  // A moved chunk reports both an allocation and a free.
  a_move_both: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[69] |->
      m_tdata[1:0] != scfcc_pkg::ALLOC_NONE && m_tdata[67:66] != scfcc_pkg::FREE_NONE)
    else $error("moved chunk missing allocate or free");

  // Reset drops any pending result.
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind size_class_free_chunk_cache scfcc_checker u_scfcc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
